### rtl/core/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and constants of the LED matrix row scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package lmrs_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int ROWS_DEF       = 7;

  localparam int BRIGHT_W  = 7;
  localparam int DUR_W     = 16;
  localparam int NFR_W     = 4;
  localparam int PERIOD_W  = 12;
  localparam int DUR_US_W  = 26;
  localparam int ELAPSED_W = 27;
  localparam int PROD_W    = PERIOD_W + BRIGHT_W;
  localparam int QEST_W    = PERIOD_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [BRIGHT_W-1:0]  BRIGHT_FULL   = 7'd100;
  localparam logic [9:0]           US_PER_MS     = 10'd1000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 27'h7FF_FFFF;

  // floor(x/100) for x below 2**19: (x*DIV100_MUL)>>DIV100_SHIFT is exact or one high
  localparam logic [12:0]          DIV100_MUL    = 13'd5243;
  localparam int                   DIV100_SHIFT  = 19;
  localparam logic [6:0]           HUNDRED       = 7'd100;

  localparam logic [BRIGHT_W-1:0]  BRIGHT_RST    = 7'd100;
  localparam logic [DUR_W-1:0]     DUR_RST       = 16'd1000;
  localparam logic [NFR_W-1:0]     NFR_RST       = 4'd5;
  localparam logic [PERIOD_W-1:0]  PERIOD_RST    = 12'd1000;

  localparam logic [1:0]           SETTLE_CYCLES = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_DURATION   = 2'd1,
    CFG_FRAMES     = 2'd2,
    CFG_PERIOD     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] on_us;
    logic [PERIOD_W-1:0] period_us;
    logic [DUR_US_W-1:0] dur_us;
    logic [NFR_W-1:0]    frames_in_use;
    logic                hold;
  } lmrs_timing_t;

endpackage

`default_nettype wire

### rtl/core/lmrs_cfg.sv
// ----------------------------------------------------------------------------
// lmrs_cfg
// Configuration registers and the derived row timing (on time, frame length).
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_cfg (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [lmrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [lmrs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output lmrs_pkg::lmrs_timing_t             timing
);
  import lmrs_pkg::*;

  logic [BRIGHT_W-1:0] bright_r;
  logic [DUR_W-1:0]    dur_r;
  logic [NFR_W-1:0]    nfr_r;
  logic [PERIOD_W-1:0] period_r;
  logic [1:0]          settle_r;

  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   prod_d_r;
  logic [QEST_W-1:0]   qest_r;
  logic [PERIOD_W-1:0] on_r;
  logic [DUR_US_W-1:0] dur_us_r;

  logic [BRIGHT_W-1:0] bright_sat;
  logic [31:0]         qest_full;
  logic [19:0]         qest_x100;
  logic                cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= BRIGHT_RST;
      dur_r    <= DUR_RST;
      nfr_r    <= NFR_RST;
      period_r <= PERIOD_RST;
      settle_r <= SETTLE_CYCLES;
    end else begin
      if (cfg_wr) begin
        settle_r <= SETTLE_CYCLES;
        case (cfg_idx_t'(cfg_index))
          CFG_BRIGHTNESS: bright_r <= cfg_data[BRIGHT_W-1:0];
          CFG_DURATION:   dur_r    <= cfg_data[DUR_W-1:0];
          CFG_FRAMES:     nfr_r    <= cfg_data[NFR_W-1:0];
          CFG_PERIOD:     period_r <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  assign bright_sat = (bright_r > BRIGHT_FULL) ? BRIGHT_FULL : bright_r;
  assign qest_full  = 32'(prod_r) * 32'(DIV100_MUL);
  assign qest_x100  = 20'(qest_r) * 20'(HUNDRED);

  always_ff @(posedge clk) begin
    prod_r   <= PROD_W'(period_r) * PROD_W'(bright_sat);
    dur_us_r <= DUR_US_W'(dur_r) * DUR_US_W'(US_PER_MS);
    prod_d_r <= prod_r;
    qest_r   <= QEST_W'(qest_full >> DIV100_SHIFT);
    on_r     <= (qest_x100 > 20'(prod_d_r)) ? PERIOD_W'(qest_r - QEST_W'(1))
                                            : PERIOD_W'(qest_r);
  end

  always_comb begin
    timing.on_us         = on_r;
    timing.period_us     = period_r;
    timing.dur_us        = dur_us_r;
    timing.frames_in_use = nfr_r;
    timing.hold          = (settle_r != 2'd0) || cfg_valid;
  end

endmodule

`default_nettype wire

### rtl/core/lmrs_store.sv
// ----------------------------------------------------------------------------
// lmrs_store
// Frame store: one write port, two registered read ports, entry zero mirrored.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_store #(
  parameter int MAX_FRAMES = lmrs_pkg::MAX_FRAMES_DEF,
  parameter int ROWS       = lmrs_pkg::ROWS_DEF,
  parameter int DEPTH      = MAX_FRAMES * ROWS,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           wr_en,
  input  wire  [AW-1:0] wr_addr,
  input  wire  [7:0]    wr_data,
  input  wire  [AW-1:0] rd_addr_a,
  input  wire  [AW-1:0] rd_addr_b,
  output logic [7:0]    rd_data_a,
  output logic [7:0]    rd_data_b,
  output logic [7:0]    rd_data_zero
);
  import lmrs_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [7:0]       mem_a_r;
  logic [7:0]       mem_b_r;
  logic [7:0]       wd_r;
  logic             byp_a_r;
  logic             byp_b_r;
  logic             vld_a_r;
  logic             vld_b_r;
  logic [7:0]       zero_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_a_r <= mem[rd_addr_a];
    mem_b_r <= mem[rd_addr_b];
    wd_r    <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      zero_r  <= 8'd0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (wr_en && (wr_addr == AW'(0))) begin
        zero_r <= wr_data;
      end
      byp_a_r <= wr_en && (wr_addr == rd_addr_a);
      byp_b_r <= wr_en && (wr_addr == rd_addr_b);
      vld_a_r <= valid_r[rd_addr_a];
      vld_b_r <= valid_r[rd_addr_b];
    end
  end

  assign rd_data_a    = byp_a_r ? wd_r : (vld_a_r ? mem_a_r : 8'd0);
  assign rd_data_b    = byp_b_r ? wd_r : (vld_b_r ? mem_b_r : 8'd0);
  assign rd_data_zero = zero_r;

endmodule

`default_nettype wire

### rtl/core/lmrs_scan.sv
// ----------------------------------------------------------------------------
// lmrs_scan
// Row and frame sequencer with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_scan #(
  parameter int MAX_FRAMES = lmrs_pkg::MAX_FRAMES_DEF,
  parameter int ROWS       = lmrs_pkg::ROWS_DEF,
  parameter int DEPTH      = MAX_FRAMES * ROWS,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int FW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  parameter int RW         = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_kind,
  input  wire  [2:0]                   in_load_frame,
  input  wire  [2:0]                   in_load_row,
  input  wire  [7:0]                   in_row_bits,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [7:0]                   out_row_drive,
  output logic [7:0]                   out_column_drive,
  output logic [2:0]                   out_frame_shown,
  input  lmrs_pkg::lmrs_timing_t       timing,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [7:0]                   wr_data,
  output logic [AW-1:0]                rd_addr_a,
  output logic [AW-1:0]                rd_addr_b,
  input  wire  [7:0]                   rd_data_a,
  input  wire  [7:0]                   rd_data_b,
  input  wire  [7:0]                   rd_data_zero
);
  import lmrs_pkg::*;

  logic [PERIOD_W-1:0]  slot_r,    slot_nxt;
  logic [RW-1:0]        row_r,     row_nxt;
  logic [FW-1:0]        frame_r,   frame_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_row_r;
  logic [7:0]           out_col_r;
  logic [2:0]           out_frame_r;

  logic                 accept;
  logic                 is_tick;
  logic                 is_load;
  logic [AW-1:0]        cur_addr;
  logic [FW:0]          n_frames;
  logic [FW:0]          frame_inc;
  logic                 advance;
  logic                 wrap;
  logic [FW-1:0]        frame_new;
  logic [FW:0]          frame_new_inc;
  logic [7:0]           byte_sel;
  logic [7:0]           byte_now;
  logic                 lit;
  logic [7:0]           row_drive;
  logic [7:0]           col_drive;
  logic [PERIOD_W-1:0]  slot_len;
  logic [PERIOD_W:0]    slot_inc;
  logic [RW:0]          row_inc;
  logic [ELAPSED_W-1:0] elapsed_base;

  assign in_stall = (out_valid_r && out_stall) || timing.hold;
  assign accept   = in_valid && !in_stall;
  assign is_tick  = accept && (item_kind_t'(in_kind) == KIND_TICK);
  assign is_load  = accept && (item_kind_t'(in_kind) == KIND_LOAD);

  assign wr_en   = is_load && (int'(in_load_frame) < MAX_FRAMES) && (int'(in_load_row) < ROWS);
  assign wr_addr = AW'(int'(in_load_frame) * ROWS + int'(in_load_row));
  assign wr_data = in_row_bits;

  assign cur_addr = AW'(int'(frame_r) * ROWS + int'(row_r));

  always_comb begin
    if (timing.frames_in_use == NFR_W'(0)) begin
      n_frames = (FW+1)'(1);
    end else if (int'(timing.frames_in_use) > MAX_FRAMES) begin
      n_frames = (FW+1)'(MAX_FRAMES);
    end else begin
      n_frames = (FW+1)'(timing.frames_in_use);
    end
  end

  assign frame_inc = {1'b0, frame_r} + (FW+1)'(1);
  assign wrap      = frame_inc >= n_frames;
  assign advance   = is_tick && (row_r == RW'(0)) && (slot_r == PERIOD_W'(0)) &&
                     (elapsed_r >= ELAPSED_W'(timing.dur_us));
  assign frame_new = advance ? (wrap ? FW'(0) : frame_inc[FW-1:0]) : frame_r;

  always_comb begin
    if (advance) begin
      byte_sel = wrap ? rd_data_zero : rd_data_b;
    end else begin
      byte_sel = rd_data_a;
    end
    byte_now = (wr_en && (wr_addr == cur_addr)) ? wr_data : byte_sel;
  end

  assign lit       = (timing.on_us != PERIOD_W'(0)) && (byte_now != 8'd0) &&
                     (slot_r < timing.on_us);
  assign row_drive = lit ? (8'h80 >> row_r) : 8'd0;
  assign col_drive = lit ? byte_now : 8'd0;

  always_comb begin
    if ((timing.on_us != PERIOD_W'(0)) && (byte_now != 8'd0)) begin
      slot_len = timing.period_us;
    end else begin
      slot_len = timing.period_us - timing.on_us;
    end
    if (slot_len == PERIOD_W'(0)) begin
      slot_len = PERIOD_W'(1);
    end
  end

  assign slot_inc     = {1'b0, slot_r} + (PERIOD_W+1)'(1);
  assign row_inc      = {1'b0, row_r} + (RW+1)'(1);
  assign elapsed_base = advance ? ELAPSED_W'(0) : elapsed_r;

  always_comb begin
    slot_nxt    = slot_r;
    row_nxt     = row_r;
    frame_nxt   = frame_r;
    elapsed_nxt = elapsed_r;
    if (is_tick) begin
      frame_nxt   = frame_new;
      elapsed_nxt = (elapsed_base < ELAPSED_MAX) ? elapsed_base + ELAPSED_W'(1)
                                                 : elapsed_base;
      if (slot_inc >= {1'b0, slot_len}) begin
        slot_nxt = PERIOD_W'(0);
        row_nxt  = (row_inc >= (RW+1)'(ROWS)) ? RW'(0) : row_inc[RW-1:0];
      end else begin
        slot_nxt = slot_inc[PERIOD_W-1:0];
      end
    end
  end

  assign frame_new_inc = {1'b0, frame_nxt} + (FW+1)'(1);
  assign rd_addr_a     = AW'(int'(frame_nxt) * ROWS + int'(row_nxt));
  assign rd_addr_b     = (int'(frame_new_inc) < MAX_FRAMES) ?
                         AW'(int'(frame_new_inc) * ROWS) : AW'(0);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      row_r       <= '0;
      frame_r     <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      row_r       <= row_nxt;
      frame_r     <= frame_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_row_r   <= row_drive;
      out_col_r   <= col_drive;
      out_frame_r <= 3'(frame_new);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_drive    = out_row_r;
  assign out_column_drive = out_col_r;
  assign out_frame_shown  = out_frame_r;

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_r) < ROWS)
    else $error("row index beyond matrix");

  a_frame_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(frame_r) < MAX_FRAMES)
    else $error("frame index beyond store");

  a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_row_r))
    else $error("row drive not one-hot");

  a_blank_cols: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_row_r == 8'd0)) |-> (out_col_r == 8'd0))
    else $error("columns driven on a blank row");

  a_slot_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick && (row_nxt != row_r)) |=> (slot_r == PERIOD_W'(0)))
    else $error("row advanced without slot restart");

endmodule

`default_nettype wire

### rtl/core/led_matrix_row_scanner_top.sv
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_top
// Row-multiplexed LED matrix driver with PWM brightness and a frame store.
//
// Input channel (in_valid/in_stall): each item is a one-microsecond tick or
// a load of one column byte into the frame store. Every accepted item yields
// exactly one result on the output channel (out_valid/out_stall) carrying
// the row select byte, the column byte and the frame index shown.
// out_valid rises in the cycle after the input transfer; one item is taken
// every cycle while in_stall is low, set by the single register stage of
// the sequencer and the registered read of the frame store.
// A full result register lets the next item in while out_stall is low; while
// out_stall holds a waiting result, in_stall rises and the result holds.
// The configuration port writes one register per transfer (cfg_ready is
// always high); the on time and frame length are recomputed in a three-stage
// pipeline, so in_stall stays high during a write and while the settle
// counter runs down after it and after reset. Reset clears the sequencer and
// the frame store valid bits and sets the registers to their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_row_scanner_top #(
  parameter int MAX_FRAMES = lmrs_pkg::MAX_FRAMES_DEF,
  parameter int ROWS       = lmrs_pkg::ROWS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_kind,
  input  wire  [2:0]                       in_load_frame,
  input  wire  [2:0]                       in_load_row,
  input  wire  [7:0]                       in_row_bits,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [7:0]                       out_row_drive,
  output logic [7:0]                       out_column_drive,
  output logic [2:0]                       out_frame_shown,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [lmrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [lmrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lmrs_pkg::*;

  localparam int DEPTH = MAX_FRAMES * ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lmrs_timing_t  timing;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [7:0]    rd_data_a;
  logic [7:0]    rd_data_b;
  logic [7:0]    rd_data_zero;

  lmrs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  lmrs_store #(
    .MAX_FRAMES (MAX_FRAMES),
    .ROWS       (ROWS)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .rd_data_a    (rd_data_a),
    .rd_data_b    (rd_data_b),
    .rd_data_zero (rd_data_zero)
  );

  lmrs_scan #(
    .MAX_FRAMES (MAX_FRAMES),
    .ROWS       (ROWS)
  ) u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_load_frame    (in_load_frame),
    .in_load_row      (in_load_row),
    .in_row_bits      (in_row_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_drive    (out_row_drive),
    .out_column_drive (out_column_drive),
    .out_frame_shown  (out_frame_shown),
    .timing           (timing),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_addr_a        (rd_addr_a),
    .rd_addr_b        (rd_addr_b),
    .rd_data_a        (rd_data_a),
    .rd_data_b        (rd_data_b),
    .rd_data_zero     (rd_data_zero)
  );

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED matrix row scanner. Ticks and frame-row
// loads go through the valid/stall input channel. A cycle-level predictor of
// the sweep, slot and frame timing queues one expected drive per accepted
// item, and every transfer on the result channel is checked field by field.
// Directed cases come first, then randomized traffic under several register
// settings, with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmrs_pkg::*;

  localparam int FRAMES = MAX_FRAMES_DEF;
  localparam int ROW_COUNT = ROWS_DEF;

  typedef struct packed {
    logic [7:0] row_drive;
    logic [7:0] column_drive;
    logic [2:0] frame_shown;
  } drive_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  item_kind_t            in_kind = KIND_TICK;
  logic [2:0]            in_load_frame = '0;
  logic [2:0]            in_load_row = '0;
  logic [7:0]            in_row_bits = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_row_drive;
  logic [7:0]            out_column_drive;
  logic [2:0]            out_frame_shown;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_BRIGHTNESS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drive_t      drive_q[$];
  int unsigned errors = 0;
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_run = 0;

  logic [7:0]  store_m [FRAMES*ROW_COUNT];
  int unsigned slot_m, row_m, frame_m, elapsed_m;
  int unsigned bright_m, dur_m, nfr_m, period_m;

  led_matrix_row_scanner_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_load_frame    (in_load_frame),
    .in_load_row      (in_load_row),
    .in_row_bits      (in_row_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_drive    (out_row_drive),
    .out_column_drive (out_column_drive),
    .out_frame_shown  (out_frame_shown),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned lit_time();
    int unsigned b;
    b = (bright_m > BRIGHT_FULL) ? BRIGHT_FULL : bright_m;
    return (period_m * b) / HUNDRED;
  endfunction

  function automatic logic [7:0] cur_byte();
    if (frame_m >= FRAMES || row_m >= ROW_COUNT) return 8'd0;
    return store_m[frame_m*ROW_COUNT + row_m];
  endfunction

  function automatic drive_t shown();
    drive_t      d;
    int unsigned lit_us;
    logic [7:0]  b;
    lit_us = lit_time();
    b = cur_byte();
    d.frame_shown = 3'(frame_m);
    if (lit_us > 0 && b != 8'd0 && slot_m < lit_us) begin
      d.row_drive = 8'(1 << ((7 - row_m) & 7));
      d.column_drive = b;
    end else begin
      d.row_drive = 8'd0;
      d.column_drive = 8'd0;
    end
    return d;
  endfunction

  function automatic void scan_step(item_kind_t kind, logic [2:0] f, logic [2:0] r,
                                    logic [7:0] bits);
    int unsigned lit_us, dark_us, len, n;
    if (kind == KIND_LOAD) begin
      if (f < FRAMES && r < ROW_COUNT) store_m[f*ROW_COUNT + r] = bits;
      drive_q.push_back(shown());
      return;
    end
    if (row_m == 0 && slot_m == 0 && elapsed_m >= dur_m * US_PER_MS) begin
      n = nfr_m;
      if (n == 0) n = 1;
      if (n > FRAMES) n = FRAMES;
      frame_m++;
      if (frame_m >= n) frame_m = 0;
      elapsed_m = 0;
    end
    drive_q.push_back(shown());
    lit_us = lit_time();
    dark_us = period_m - lit_us;
    len = ((lit_us > 0 && cur_byte() != 8'd0) ? lit_us : 0) + dark_us;
    if (len == 0) len = 1;
    if (elapsed_m < ELAPSED_MAX) elapsed_m++;
    slot_m++;
    if (slot_m >= len) begin
      slot_m = 0;
      row_m++;
      if (row_m >= ROW_COUNT) row_m = 0;
    end
  endfunction

  function automatic void reset_model();
    foreach (store_m[i]) store_m[i] = 8'd0;
    slot_m = 0;
    row_m = 0;
    frame_m = 0;
    elapsed_m = 0;
    bright_m = BRIGHT_RST;
    dur_m = DUR_RST;
    nfr_m = NFR_RST;
    period_m = PERIOD_RST;
  endfunction

  // ------------------------------------------------------------ result check

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s expected %02h actual %02h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    drive_t exp_d;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none actual %02h %02h %0d",
                 $time, out_row_drive, out_column_drive, out_frame_shown);
      end else begin
        exp_d = drive_q.pop_front();
        check_field("row_drive", exp_d.row_drive, out_row_drive);
        check_field("column_drive", exp_d.column_drive, out_column_drive);
        check_field("frame_shown", 8'(exp_d.frame_shown), 8'(out_frame_shown));
      end
    end
  end

  // ---------------------------------------------------------------- idling

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 94) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_run <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // -------------------------------------------------------------- drivers

  task automatic send_item(item_kind_t kind, logic [2:0] f, logic [2:0] r, logic [7:0] bits);
    int unsigned gap;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_load_frame <= f;
    in_load_row <= r;
    in_row_bits <= bits;
    do @(posedge clk); while (in_stall);
    scan_step(kind, f, r, bits);
    gap = (!tx_calm && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(KIND_TICK, 3'($urandom), 3'($urandom), 8'($urandom));
  endtask

  task automatic send_random();
    int unsigned r;
    logic [7:0]  bits;
    r = $urandom_range(0, 99);
    bits = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
    if (r < 68) send_ticks(1);
    else if (r < 97) send_item(KIND_LOAD, 3'($urandom), 3'($urandom_range(0, 6)), bits);
    else send_item(KIND_LOAD, 3'($urandom), 3'd7, bits);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_regs(int unsigned b, int unsigned d, int unsigned n, int unsigned p);
    cfg_idx_t              regs [4];
    logic [CFG_DATA_W-1:0] word;
    regs = '{CFG_BRIGHTNESS, CFG_DURATION, CFG_FRAMES, CFG_PERIOD};
    drain();
    cfg_valid <= 1'b1;
    foreach (regs[i]) begin
      word = CFG_DATA_W'($urandom);
      case (regs[i])
        CFG_BRIGHTNESS: word[BRIGHT_W-1:0] = BRIGHT_W'(b);
        CFG_DURATION:   word[DUR_W-1:0] = DUR_W'(d);
        CFG_FRAMES:     word[NFR_W-1:0] = NFR_W'(n);
        CFG_PERIOD:     word[PERIOD_W-1:0] = PERIOD_W'(p);
        default: ;
      endcase
      cfg_index <= regs[i];
      cfg_data <= word;
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        CFG_BRIGHTNESS: bright_m = word[BRIGHT_W-1:0];
        CFG_DURATION:   dur_m = word[DUR_W-1:0];
        CFG_FRAMES:     nfr_m = word[NFR_W-1:0];
        CFG_PERIOD:     period_m = word[PERIOD_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_ticks(2);
  endtask

  task automatic test_frame_loads();
    send_item(KIND_LOAD, 3'd0, 3'd0, 8'hFF);
    send_item(KIND_LOAD, 3'd7, 3'd6, 8'h80);
    send_item(KIND_LOAD, 3'd4, 3'd7, 8'hA5);
    send_item(KIND_LOAD, 3'd0, 3'd1, 8'h01);
    send_item(KIND_LOAD, 3'd1, 3'd0, 8'h3C);
    send_item(KIND_LOAD, 3'd0, 3'd2, 8'h00);
  endtask

  task automatic test_sweep_and_advance();
    program_regs(127, 0, 0, 1);
    send_ticks(8);
  endtask

  task automatic test_frame_cycling();
    program_regs(100, 0, 15, 1);
    send_ticks(8);
  endtask

  task automatic test_zero_length_slot();
    program_regs(50, 0, 2, 0);
    send_ticks(3);
  endtask

  task automatic test_config_mid_slot();
    program_regs(100, 65535, 8, 4095);
    send_ticks(4);
    program_regs(0, 1, 1, 2);
    send_ticks(2);
  endtask

  task automatic test_backpressure();
    program_regs(100, 0, 8, 3);
    hold_left <= 400;
    tx_calm <= 1'b1;
    repeat (60) send_random();
    tx_calm <= 1'b0;
    drain();
  endtask

  task automatic test_random_scan();
    int unsigned b, d, n, p;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0:       b = 0;
        1:       b = 100;
        2:       b = $urandom_range(101, 127);
        default: b = $urandom_range(1, 99);
      endcase
      case ($urandom_range(0, 3))
        2:       d = 1;
        3:       d = $urandom_range(2, 65535);
        default: d = 0;
      endcase
      case ($urandom_range(0, 9))
        0:       p = 0;
        1:       p = $urandom_range(13, 4095);
        default: p = $urandom_range(1, 12);
      endcase
      n = $urandom_range(0, 15);
      program_regs(b, d, n, p);
      tx_calm <= (ph == 2);
      rx_calm <= (ph == 2);
      repeat (200) send_random();
    end
    tx_calm <= 1'b0;
    rx_calm <= 1'b0;
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_frame_loads();
    test_sweep_and_advance();
    test_frame_cycling();
    test_zero_length_slot();
    test_config_mid_slot();
    test_backpressure();
    test_random_scan();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
rtl/core/lmrs_pkg.sv
rtl/core/lmrs_cfg.sv
rtl/core/lmrs_store.sv
rtl/core/lmrs_scan.sv
rtl/core/led_matrix_row_scanner_top.sv
test/tb.sv
